// ===== hw/rtl/lsac_pkg.sv =====
package lsac_pkg;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_COLD    = 2'd1;
  localparam logic [1:0] OUT_EVICT   = 2'd2;
  localparam logic [1:0] OUT_IGNORED = 2'd3;

  localparam logic [1:0] CFG_SET_IDX  = 2'd0;
  localparam logic [1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS     = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] address;
  } lsac_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        modify_hit;
    logic [7:0]  set_index;
    logic [31:0] line_offset;
    logic [31:0] hits_total;
    logic [31:0] misses_total;
    logic [31:0] evictions_total;
  } lsac_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_WRITE, ST_RESP
  } lsac_state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic rd;
    logic eval;
    logic wr;
  } lsac_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic nop;
    logic scan_done;
  } lsac_sts_t;

endpackage

// ===== hw/rtl/lru_set_assoc_cache_sim.sv =====
// Set-associative cache with true LRU replacement, command style: an access
// is taken when start is high and busy low, and its result appears on out_data
// for exactly one cycle with out_valid; the receiver cannot stall, so it must
// take every strobe. An access scans k ways (1 to ways_in_use) in turn: each
// way is one read of the single-port line store and one compare, and the
// chosen way is then written back. An ignored command reads once and scans
// nothing. After reset the block is busy while it clears all entries of the
// valid store, (2**MAX_SET_INDEX_BITS)*MAX_WAYS of them (2048 by default);
// configuration writes are always taken and do not flush the cache.
module lru_set_assoc_cache_sim import lsac_pkg::*; #(
  parameter int MAX_SET_INDEX_BITS = 8,
  parameter int MAX_WAYS           = 8,
  parameter int ADDR_WIDTH         = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  lsac_in_t   in_data,
  output logic       out_valid,
  output lsac_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);

  lsac_cmd_t cmd;
  lsac_sts_t sts;

  assign cfg_ready = 1'b1;

  lsac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lsac_dp #(
    .MAX_SET_INDEX_BITS (MAX_SET_INDEX_BITS),
    .MAX_WAYS           (MAX_WAYS),
    .ADDR_WIDTH         (ADDR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/lsac_ctrl.sv =====
module lsac_ctrl import lsac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lsac_sts_t sts,
  output lsac_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  lsac_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = sts.nop ? ST_WRITE : ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.scan_done ? ST_WRITE : ST_READ;
      end
      ST_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ===== hw/rtl/lsac_dp.sv =====
module lsac_dp import lsac_pkg::*; #(
  parameter int MAX_SET_INDEX_BITS = 8,
  parameter int MAX_WAYS           = 8,
  parameter int ADDR_WIDTH         = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lsac_cmd_t  cmd,
  output lsac_sts_t  sts,
  input  lsac_in_t   in_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  output lsac_out_t  out_data
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int DEPTH  = (1 << MAX_SET_INDEX_BITS) * MAX_WAYS;
  localparam int LINE_W = $clog2(DEPTH);
  localparam int TAG_W  = ADDR_WIDTH - 2;

  logic [3:0] sidx_bits_r, ways_cfg_r;
  logic [5:0] off_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_bits_r <= 4'd4;
      off_bits_r  <= 6'd4;
      ways_cfg_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_IDX:  sidx_bits_r <= cfg_data[3:0];
        CFG_OFF_BITS: off_bits_r  <= cfg_data;
        CFG_WAYS:     ways_cfg_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped split of the incoming address
  logic [4:0]            s_cl;
  logic [5:0]            b_cl, w_cl;
  logic [63:0]           addr_m, off_c, set_c, tag_c;

  always_comb begin
    if (sidx_bits_r == 4'd0)                           s_cl = 5'd1;
    else if (5'(sidx_bits_r) > 5'(MAX_SET_INDEX_BITS)) s_cl = 5'(MAX_SET_INDEX_BITS);
    else                                               s_cl = 5'(sidx_bits_r);
    if (off_bits_r == 6'd0)       b_cl = 6'd1;
    else if (off_bits_r > 6'd32)  b_cl = 6'd32;
    else                          b_cl = off_bits_r;
    if (ways_cfg_r == 4'd0)                       w_cl = 6'd1;
    else if (6'(ways_cfg_r) > 6'(MAX_WAYS))       w_cl = 6'(MAX_WAYS);
    else                                          w_cl = 6'(ways_cfg_r);
    addr_m = in_data.address & ({64{1'b1}} >> (64 - ADDR_WIDTH));
    off_c  = addr_m & ((64'd1 << b_cl) - 64'd1);
    set_c  = (addr_m >> b_cl) & ((64'd1 << s_cl) - 64'd1);
    tag_c  = addr_m >> (7'(s_cl) + 7'(b_cl));
  end

  logic [1:0]                   cmd_r;
  logic [31:0]                  off_r;
  logic [MAX_SET_INDEX_BITS-1:0] set_r;
  logic [TAG_W-1:0]             tag_r;
  logic [5:0]                   ways_r;
  logic [WAY_W-1:0]             way_r, pick_r;
  logic [63:0]                  pick_stamp_r;
  logic [1:0]                   outcome_r;

  logic [TAG_W-1:0] tag_mem   [DEPTH];
  logic [63:0]      stamp_mem [DEPTH];
  logic             valid_mem [DEPTH];
  logic [TAG_W-1:0] tag_q;
  logic [63:0]      stamp_q;
  logic             valid_q;

  logic [LINE_W-1:0] clr_r;
  logic [LINE_W-1:0] rd_line, pick_line;

  assign rd_line   = LINE_W'(set_r) * LINE_W'(MAX_WAYS) + LINE_W'(way_r);
  assign pick_line = LINE_W'(set_r) * LINE_W'(MAX_WAYS) + LINE_W'(pick_r);

  logic [63:0] access_r;
  logic [31:0] hits_r, misses_r, evict_r;

  logic ev_cold, ev_hit, ev_last;
  assign ev_cold = !valid_q;
  assign ev_hit  = valid_q && (tag_q == tag_r);
  assign ev_last = (6'(way_r) + 6'd1) == ways_r;

  assign sts.clear_done = clr_r == LINE_W'(DEPTH - 1);
  assign sts.nop        = cmd_r == CMD_NOP;
  assign sts.scan_done  = ev_cold || ev_hit || ev_last;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear_step) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) valid_mem[clr_r] <= 1'b0;
    else if (cmd.wr && !sts.nop && outcome_r != OUT_HIT) valid_mem[pick_line] <= 1'b1;
    if (cmd.wr && !sts.nop) begin
      stamp_mem[pick_line] <= access_r + 64'd1;
      if (outcome_r != OUT_HIT) tag_mem[pick_line] <= tag_r;
    end
    if (cmd.rd) begin
      tag_q   <= tag_mem[rd_line];
      stamp_q <= stamp_mem[rd_line];
      valid_q <= valid_mem[rd_line];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_data.cmd;
      off_r     <= off_c[31:0];
      set_r     <= set_c[MAX_SET_INDEX_BITS-1:0];
      tag_r     <= tag_c[TAG_W-1:0];
      ways_r    <= w_cl;
      way_r     <= '0;
      pick_r    <= '0;
      outcome_r <= OUT_EVICT;
    end else if (cmd.eval) begin
      if (ev_cold || ev_hit) begin
        outcome_r <= ev_cold ? OUT_COLD : OUT_HIT;
        pick_r    <= way_r;
      end else begin
        if (way_r == '0 || stamp_q < pick_stamp_r) begin
          pick_r       <= way_r;
          pick_stamp_r <= stamp_q;
        end
        way_r <= way_r + 1'b1;
      end
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
    sat_inc = (en && v != '1) ? v + 32'd1 : v;
  endfunction

  logic [31:0] hits_1;
  logic        is_mod;
  assign is_mod = cmd_r == CMD_MODIFY;
  assign hits_1 = sat_inc(hits_r, outcome_r == OUT_HIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_r <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evict_r  <= '0;
    end else if (cmd.wr && !sts.nop) begin
      access_r <= access_r + 64'd1;
      hits_r   <= sat_inc(hits_1, is_mod);
      misses_r <= sat_inc(misses_r, outcome_r != OUT_HIT);
      evict_r  <= sat_inc(evict_r, outcome_r == OUT_EVICT);
    end
  end

  // payload of the response is formed in the write cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_data.outcome      <= sts.nop ? OUT_IGNORED : outcome_r;
      out_data.modify_hit   <= is_mod;
      out_data.set_index    <= 8'(set_r);
      out_data.line_offset  <= off_r;
      if (sts.nop) begin
        out_data.hits_total      <= hits_r;
        out_data.misses_total    <= misses_r;
        out_data.evictions_total <= evict_r;
      end else begin
        out_data.hits_total      <= sat_inc(hits_1, is_mod);
        out_data.misses_total    <= sat_inc(misses_r, outcome_r != OUT_HIT);
        out_data.evictions_total <= sat_inc(evict_r, outcome_r == OUT_EVICT);
      end
    end
  end

endmodule
